/* sv/mpqh_pkg.sv */
// Shared types, constants and the crypt table generator for the MPQ string hash.
// Used by every module of the mpq_string_hash block; depends on nothing.
package mpqh_pkg;

    localparam int HASH_TYPES   = 3;
    localparam int ROWS_GEN     = 5;
    localparam int ROW_LEN      = 256;
    localparam int CRYPT_DEPTH  = HASH_TYPES * ROW_LEN;
    localparam int CHAR_W       = 8;
    localparam int WORD_W       = 32;
    localparam int SIZE_W       = 21;
    localparam int INDEX_W      = 20;
    localparam int TYPE_W       = 2;

    localparam logic [WORD_W-1:0] SEED_ONE_INIT = 32'h7FED_7FED;
    localparam logic [WORD_W-1:0] SEED_TWO_INIT = 32'hEEEE_EEEE;
    localparam logic [WORD_W-1:0] GEN_START     = 32'h0010_0001;
    localparam logic [WORD_W-1:0] GEN_MOD       = 32'h002A_AAAB;
    localparam logic [WORD_W-1:0] GEN_MUL       = 32'd125;
    localparam logic [WORD_W-1:0] GEN_ADD       = 32'd3;
    localparam logic [WORD_W-1:0] HALF_MASK     = 32'h0000_FFFF;
    localparam logic [WORD_W-1:0] SEED_ADD      = 32'd3;

    localparam logic [SIZE_W-1:0] SLOT_COUNT_RESET = 21'd1024;

    localparam logic [CHAR_W-1:0] LOWER_A    = 8'h61;
    localparam logic [CHAR_W-1:0] LOWER_Z    = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_DELTA = 8'h20;

    typedef logic [CRYPT_DEPTH-1:0][WORD_W-1:0] crypt_rom_t;
    typedef logic [HASH_TYPES-1:0][WORD_W-1:0]  word_vec_t;

    // one byte advancing through the seed update
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [CHAR_W-1:0] ch;
    } mpqh_step_t;

    function automatic logic [WORD_W-1:0] gen_next(input logic [WORD_W-1:0] s);
        return (s * GEN_MUL + GEN_ADD) % GEN_MOD;
    endfunction

    // five rows are drawn column by column; only the first three are kept
    function automatic crypt_rom_t build_crypt();
        crypt_rom_t        tbl;
        logic [WORD_W-1:0] s;
        logic [WORD_W-1:0] hi;
        tbl = '0;
        s   = GEN_START;
        for (int col = 0; col < ROW_LEN; col++) begin
            for (int row = 0; row < ROWS_GEN; row++) begin
                s  = gen_next(s);
                hi = (s & HALF_MASK) << 16;
                s  = gen_next(s);
                if (row < HASH_TYPES) begin
                    tbl[row * ROW_LEN + col] = hi | (s & HALF_MASK);
                end
            end
        end
        return tbl;
    endfunction

endpackage

/* sv/mpqh_crypt_rom.sv */
// Crypt table ROM: one row per hash type, all three rows read per byte.
// Contents built at elaboration by mpqh_pkg::build_crypt; read data is registered.
module mpqh_crypt_rom
    import mpqh_pkg::*;
(
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [CHAR_W-1:0] rd_ch,
    output word_vec_t         rd_data
);

    localparam crypt_rom_t CRYPT_ROM = build_crypt();

    word_vec_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            for (int t = 0; t < HASH_TYPES; t++) begin
                rd_data_reg[t] <= CRYPT_ROM[{TYPE_W'(t), rd_ch}];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/mpqh_seed_unit.sv */
// Seed pair registers for the three hash types and their per-byte update.
// Uses mpqh_pkg types; fed by the crypt ROM read data of the same byte.
module mpqh_seed_unit
    import mpqh_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  mpqh_step_t step,
    input  word_vec_t  crypt_word,
    output word_vec_t  hash_out
);

    word_vec_t seed_one_reg, seed_one_next;
    word_vec_t seed_two_reg, seed_two_next;
    word_vec_t s1;

    always_comb begin
        for (int t = 0; t < HASH_TYPES; t++) begin
            s1[t] = crypt_word[t] ^ (seed_one_reg[t] + seed_two_reg[t]);
            seed_one_next[t] = s1[t];
            seed_two_next[t] = {{(WORD_W-CHAR_W){1'b0}}, step.ch} + s1[t] + seed_two_reg[t]
                             + (seed_two_reg[t] << 5) + SEED_ADD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int t = 0; t < HASH_TYPES; t++) begin
                seed_one_reg[t] <= SEED_ONE_INIT;
                seed_two_reg[t] <= SEED_TWO_INIT;
            end
        end else if (step.valid) begin
            for (int t = 0; t < HASH_TYPES; t++) begin
                // restart the seeds once a key is finished
                seed_one_reg[t] <= step.last ? SEED_ONE_INIT : seed_one_next[t];
                seed_two_reg[t] <= step.last ? SEED_TWO_INIT : seed_two_next[t];
            end
        end
    end

    assign hash_out = s1;

endmodule

/* sv/mpq_string_hash.sv */
// Top level of the MPQ string hash: case fold, crypt ROM read stage, seed update,
// result register and slot count register. Uses mpqh_pkg, mpqh_crypt_rom, mpqh_seed_unit.
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tdata = character, tlast = last
//  m_axis    out  m_axis_tvalid/tready       tdata = table_index, key_a, key_b
//  cfg       in   cfg_wr_en                  cfg_wr_data = slot count
//
// One byte per cycle sustained unless a last byte waits for the output register. A byte
// is held in the crypt ROM read register, then updates the seeds; a result enters the
// output register as its last byte leaves the read stage and can leave at the next edge.
// Synchronous active-low reset restores seeds and the slot count; the ROM needs no fill.
// A result waiting on m_axis_tready stalls only a last byte behind it.
module mpq_string_hash
    import mpqh_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] character
    input  logic              s_axis_tlast,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [87:0]       m_axis_tdata,   // [19:0] table_index, [51:20] key_a,
                                              // [83:52] key_b, [87:84] zero
    input  logic              cfg_wr_en,
    input  logic [SIZE_W-1:0] cfg_wr_data
);

    logic [SIZE_W-1:0] slot_count_reg;
    logic              p1_valid_reg;
    logic              p1_last_reg;
    logic [CHAR_W-1:0] p1_ch_reg;
    logic              m_valid_reg;
    logic [87:0]       m_data_reg;

    logic [CHAR_W-1:0] ch_fold;
    logic              out_free;
    logic              retire;
    logic              load;
    logic [SIZE_W-1:0] idx_mask;
    word_vec_t         crypt_word;
    word_vec_t         hash_out;
    mpqh_step_t        step;

    always_comb begin
        ch_fold = s_axis_tdata;
        if (s_axis_tdata >= LOWER_A && s_axis_tdata <= LOWER_Z) begin
            ch_fold = s_axis_tdata - CASE_DELTA;
        end
    end

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign retire        = p1_valid_reg && (!p1_last_reg || out_free);
    assign s_axis_tready = !p1_valid_reg || retire;
    assign load          = s_axis_tvalid && s_axis_tready;
    assign idx_mask      = slot_count_reg - SIZE_W'(1);

    assign step.valid = retire;
    assign step.last  = p1_last_reg;
    assign step.ch    = p1_ch_reg;

    mpqh_crypt_rom u_rom (
        .aclk    (aclk),
        .rd_en   (load),
        .rd_ch   (ch_fold),
        .rd_data (crypt_word)
    );

    mpqh_seed_unit u_seed (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .crypt_word (crypt_word),
        .hash_out   (hash_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_count_reg <= SLOT_COUNT_RESET;
        end else if (cfg_wr_en) begin
            slot_count_reg <= cfg_wr_data;
        end
    end

    // valid flag of the stage that holds the ROM read register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            p1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            p1_last_reg <= s_axis_tlast;
            p1_ch_reg   <= ch_fold;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (retire && p1_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (retire && p1_last_reg) begin
            m_data_reg <= {4'b0, hash_out[2], hash_out[1],
                           hash_out[0][INDEX_W-1:0] & idx_mask[INDEX_W-1:0]};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule
